// ===== rtl/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Shared assertion macros for the checker module of the console engine.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that when cond holds, expr holds at the next clock edge.
`define ASSERT_NEXT(lbl, clk, rstn, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) else $error(msg);

`endif

// ===== rtl/tcce_pkg.sv =====
// ============================================================================
// tcce_pkg
// Shared constants, types and codes of the text console cursor engine.
// ============================================================================
`default_nettype none

package tcce_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    // Field widths
    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 8;
    localparam int CELL_W    = CHAR_W + COLOR_W;
    localparam int COL_OUT_W = 7;
    localparam int ROW_OUT_W = 5;

    localparam int S_FIELDS_W = CMD_W + CHAR_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = COL_OUT_W + ROW_OUT_W + CHAR_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    typedef logic [COL_W-1:0]   col_t;
    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [CELL_W-1:0]  cell_t;

    localparam col_t LAST_COL = col_t'(COLUMNS - 1);
    localparam row_t LAST_ROW = row_t'(ROWS - 1);

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT       = 2'd0,
        CMD_CLEAR_ALL = 2'd1,
        CMD_CLEAR_ROW = 2'd2
    } cmd_t;

    // Character codes
    localparam char_t CH_BACKSPACE = 8'd8;
    localparam char_t CH_TAB       = 8'd9;
    localparam char_t CH_NEWLINE   = 8'd10;
    localparam char_t CH_RETURN    = 8'd13;
    localparam char_t CH_SPACE     = 8'd32;

    localparam color_t COLOR_RESET = 8'h07;

    // Screen store access requested by the sequencer
    typedef struct packed {
        logic  wr_en;
        addr_t wr_addr;
        cell_t wr_data;
        logic  rd_en;
        addr_t rd_addr;
    } ram_req_t;

    // Finished result handed to the output register
    typedef struct packed {
        logic  valid;
        col_t  col;
        row_t  row;
        char_t prev;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/tcce_ram.sv =====
// ============================================================================
// tcce_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
`default_nettype none

module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/tcce_addr.sv =====
// ============================================================================
// tcce_addr
// Shared address unit: maps a (row, column) pair to a linear cell address.
// ============================================================================
`default_nettype none

module tcce_addr (
    input  wire tcce_pkg::row_t  row,
    input  wire tcce_pkg::col_t  col,
    output tcce_pkg::addr_t      addr
);

    assign addr = tcce_pkg::addr_t'(
        tcce_pkg::addr_t'(row) * tcce_pkg::addr_t'(tcce_pkg::COLUMNS)
        + tcce_pkg::addr_t'(col));

endmodule

`default_nettype wire

// ===== rtl/tcce_seq.sv =====
// ============================================================================
// tcce_seq
// Command sequencer: cursor, screen sweeps (clear, scroll) and result fetch.
// ============================================================================
`default_nettype none

module tcce_seq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire tcce_pkg::cmd_t    cmd_in,
    input  wire tcce_pkg::char_t   char_in,
    input  wire tcce_pkg::color_t  text_color,
    input  wire logic              out_free,
    input  wire tcce_pkg::cell_t   rd_data,
    input  wire tcce_pkg::addr_t   u_addr,
    output tcce_pkg::row_t         u_row,
    output tcce_pkg::col_t         u_col,
    output tcce_pkg::ram_req_t     ram,
    output tcce_pkg::res_t         res,
    output logic                   idle
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCROLL,
        S_SCROLL_LAST,
        S_BLANK,
        S_FETCH,
        S_LOAD,
        S_EMIT
    } state_t;

    state_t           state_reg,     state_next;
    tcce_pkg::cmd_t   cmd_reg,       cmd_next;
    tcce_pkg::char_t  char_reg,      char_next;
    tcce_pkg::col_t   col_reg,       col_next;
    tcce_pkg::row_t   row_reg,       row_next;
    tcce_pkg::col_t   sw_col_reg,    sw_col_next;
    tcce_pkg::row_t   sw_row_reg,    sw_row_next;
    logic             sweep_all_reg, sweep_all_next;
    logic             init_reg,      init_next;
    logic             wpend_reg,     wpend_next;
    tcce_pkg::addr_t  prev_addr_reg, prev_addr_next;
    tcce_pkg::char_t  prev_reg,      prev_next;

    tcce_pkg::col_t   bs_col, pv_col, adv_col;
    tcce_pkg::row_t   bs_row, pv_row, adv_row;
    logic             at_home, wrap;
    tcce_pkg::color_t blank_color;

    // Neighbor positions of the cursor
    always_comb begin
        at_home = (col_reg == '0) && (row_reg == '0);
        wrap    = (col_reg == tcce_pkg::LAST_COL);

        if (col_reg != '0) begin
            pv_col = col_reg - tcce_pkg::col_t'(1);
            pv_row = row_reg;
        end else begin
            pv_col = tcce_pkg::LAST_COL;
            pv_row = row_reg - tcce_pkg::row_t'(1);
        end

        if (col_reg != '0) begin
            bs_col = col_reg - tcce_pkg::col_t'(1);
            bs_row = row_reg;
        end else if (row_reg != '0) begin
            bs_col = tcce_pkg::LAST_COL;
            bs_row = row_reg - tcce_pkg::row_t'(1);
        end else begin
            bs_col = '0;
            bs_row = '0;
        end

        if (wrap) begin
            adv_col = '0;
            adv_row = row_reg + tcce_pkg::row_t'(1);
        end else begin
            adv_col = col_reg + tcce_pkg::col_t'(1);
            adv_row = row_reg;
        end

        blank_color = init_reg ? tcce_pkg::COLOR_RESET : text_color;
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        char_next      = char_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        sw_col_next    = sw_col_reg;
        sw_row_next    = sw_row_reg;
        sweep_all_next = sweep_all_reg;
        init_next      = init_reg;
        wpend_next     = wpend_reg;
        prev_addr_next = prev_addr_reg;
        prev_next      = prev_reg;

        u_row = row_reg;
        u_col = col_reg;
        ram   = '0;
        res   = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    cmd_next   = cmd_in;
                    char_next  = char_in;
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                unique case (cmd_reg)
                    tcce_pkg::CMD_PUT: begin
                        priority if (char_reg == tcce_pkg::CH_NEWLINE) begin
                            col_next = '0;
                            if (row_reg == tcce_pkg::LAST_ROW) begin
                                sw_row_next = '0;
                                sw_col_next = '0;
                                wpend_next  = 1'b0;
                                state_next  = S_SCROLL;
                            end else begin
                                row_next   = row_reg + tcce_pkg::row_t'(1);
                                state_next = S_FETCH;
                            end
                        end else if (char_reg == tcce_pkg::CH_RETURN) begin
                            col_next   = '0;
                            state_next = S_FETCH;
                        end else if (char_reg == tcce_pkg::CH_TAB) begin
                            state_next = S_FETCH;
                        end else if (char_reg == tcce_pkg::CH_BACKSPACE) begin
                            // Step back, then blank the cell now under the cursor
                            u_row         = bs_row;
                            u_col         = bs_col;
                            ram.wr_en     = 1'b1;
                            ram.wr_addr   = u_addr;
                            ram.wr_data   = {text_color, tcce_pkg::CH_SPACE};
                            col_next      = bs_col;
                            row_next      = bs_row;
                            state_next    = S_FETCH;
                        end else begin
                            ram.wr_en   = 1'b1;
                            ram.wr_addr = u_addr;
                            ram.wr_data = {text_color, char_reg};
                            col_next    = adv_col;
                            if (wrap && (row_reg == tcce_pkg::LAST_ROW)) begin
                                sw_row_next = '0;
                                sw_col_next = '0;
                                wpend_next  = 1'b0;
                                state_next  = S_SCROLL;
                            end else begin
                                // Cell before the new cursor is the one just written
                                row_next  = adv_row;
                                prev_next = char_reg;
                                if (out_free) begin
                                    res.valid  = 1'b1;
                                    res.col    = adv_col;
                                    res.row    = adv_row;
                                    res.prev   = char_reg;
                                    state_next = S_IDLE;
                                end else begin
                                    state_next = S_EMIT;
                                end
                            end
                        end
                    end

                    tcce_pkg::CMD_CLEAR_ALL: begin
                        col_next       = '0;
                        row_next       = '0;
                        sw_col_next    = '0;
                        sw_row_next    = '0;
                        sweep_all_next = 1'b1;
                        state_next     = S_BLANK;
                    end

                    tcce_pkg::CMD_CLEAR_ROW: begin
                        col_next       = '0;
                        sw_col_next    = '0;
                        sw_row_next    = row_reg;
                        sweep_all_next = 1'b0;
                        state_next     = S_BLANK;
                    end

                    default: begin
                        state_next = S_FETCH;
                    end
                endcase
            end

            S_SCROLL: begin
                // Read one row below, write the cell read in the cycle before
                u_row          = sw_row_reg + tcce_pkg::row_t'(1);
                u_col          = sw_col_reg;
                ram.rd_en      = 1'b1;
                ram.rd_addr    = u_addr;
                ram.wr_en      = wpend_reg;
                ram.wr_addr    = prev_addr_reg - tcce_pkg::addr_t'(tcce_pkg::COLUMNS);
                ram.wr_data    = rd_data;
                prev_addr_next = u_addr;
                wpend_next     = 1'b1;
                if (sw_col_reg == tcce_pkg::LAST_COL) begin
                    sw_col_next = '0;
                    if (sw_row_reg == tcce_pkg::row_t'(tcce_pkg::ROWS - 2)) begin
                        state_next = S_SCROLL_LAST;
                    end else begin
                        sw_row_next = sw_row_reg + tcce_pkg::row_t'(1);
                    end
                end else begin
                    sw_col_next = sw_col_reg + tcce_pkg::col_t'(1);
                end
            end

            S_SCROLL_LAST: begin
                ram.wr_en      = 1'b1;
                ram.wr_addr    = prev_addr_reg - tcce_pkg::addr_t'(tcce_pkg::COLUMNS);
                ram.wr_data    = rd_data;
                sw_row_next    = tcce_pkg::LAST_ROW;
                sw_col_next    = '0;
                sweep_all_next = 1'b0;
                state_next     = S_BLANK;
            end

            S_BLANK: begin
                u_row       = sw_row_reg;
                u_col       = sw_col_reg;
                ram.wr_en   = 1'b1;
                ram.wr_addr = u_addr;
                ram.wr_data = {blank_color, tcce_pkg::CH_SPACE};
                if (sw_col_reg == tcce_pkg::LAST_COL) begin
                    sw_col_next = '0;
                    if (sweep_all_reg && (sw_row_reg != tcce_pkg::LAST_ROW)) begin
                        sw_row_next = sw_row_reg + tcce_pkg::row_t'(1);
                    end else begin
                        init_next  = 1'b0;
                        state_next = init_reg ? S_IDLE : S_FETCH;
                    end
                end else begin
                    sw_col_next = sw_col_reg + tcce_pkg::col_t'(1);
                end
            end

            S_FETCH: begin
                if (at_home) begin
                    prev_next  = tcce_pkg::CH_SPACE;
                    state_next = S_EMIT;
                end else begin
                    u_row       = pv_row;
                    u_col       = pv_col;
                    ram.rd_en   = 1'b1;
                    ram.rd_addr = u_addr;
                    state_next  = S_LOAD;
                end
            end

            S_LOAD: begin
                prev_next  = rd_data[tcce_pkg::CHAR_W-1:0];
                state_next = S_EMIT;
            end

            S_EMIT: begin
                if (out_free) begin
                    res.valid  = 1'b1;
                    res.col    = col_reg;
                    res.row    = row_reg;
                    res.prev   = prev_reg;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_BLANK;
            col_reg       <= '0;
            row_reg       <= '0;
            sw_col_reg    <= '0;
            sw_row_reg    <= '0;
            sweep_all_reg <= 1'b1;
            init_reg      <= 1'b1;
            wpend_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            sw_col_reg    <= sw_col_next;
            sw_row_reg    <= sw_row_next;
            sweep_all_reg <= sweep_all_next;
            init_reg      <= init_next;
            wpend_reg     <= wpend_next;
        end
        cmd_reg       <= cmd_next;
        char_reg      <= char_next;
        prev_addr_reg <= prev_addr_next;
        prev_reg      <= prev_next;
    end

    assign idle = (state_reg == S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/text_console_cursor_engine.sv =====
// Text console cursor engine: a character-cell screen store plus a cursor.
// Input items (s_ channel) carry a command and a character; every item yields
// exactly one result item on the m_ channel with the cursor after the command
// and the character of the cell just before it (space at the home position).
// The color byte is to be written through cfg_we/cfg_wdata only while the block is
// idle; the user must keep to this, as the block itself does not enforce it.
//
// s_tready is high only while the sequencer is idle, so a new item is not taken
// before the last one is done. The sequencer goes idle as its result is loaded
// into the output register, so the next item can be taken in the same cycle
// that the result is offered on m_tvalid.
// Sweeps are paced by the single write port of the screen RAM and the one shared
// address unit; the sequencer walks the screen one cell per cycle.
// After reset the sequencer sweeps all ROWS*COLUMNS cells to blanks with s_tready
// low; cfg writes are taken meanwhile.
// A stalled receiver holds the result in the output register; the block still
// takes the next item and parks its result until the register drains.
// ============================================================================
// text_console_cursor_engine
// Top level: config register, sequencer, address unit, screen RAM, output reg.
// ============================================================================
`default_nettype none

module text_console_cursor_engine (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Command items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tcce_pkg::S_TDATA_W-1:0]    s_tdata,  // command[1:0], char_code[9:2]
    // Result items
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [tcce_pkg::M_TDATA_W-1:0]    m_tdata,  // cursor_column[6:0],
                                                             // cursor_row[11:7],
                                                             // previous_char[19:12]
    // Color register
    input  wire logic                              cfg_we,
    input  wire logic [tcce_pkg::COLOR_W-1:0]      cfg_wdata
);

    tcce_pkg::color_t   text_color_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [tcce_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic               seq_idle;
    logic               out_free;
    tcce_pkg::res_t     res;
    tcce_pkg::ram_req_t ram;
    tcce_pkg::cell_t    rd_data;
    tcce_pkg::row_t     u_row;
    tcce_pkg::col_t     u_col;
    tcce_pkg::addr_t    u_addr;

    // Color register: plain write, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg <= tcce_pkg::COLOR_RESET;
        end else if (cfg_we) begin
            text_color_reg <= cfg_wdata;
        end
    end

    // Output register is free when empty or draining this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    tcce_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_tvalid && s_tready),
        .cmd_in     (tcce_pkg::cmd_t'(s_tdata[tcce_pkg::CMD_W-1:0])),
        .char_in    (s_tdata[tcce_pkg::CMD_W +: tcce_pkg::CHAR_W]),
        .text_color (text_color_reg),
        .out_free   (out_free),
        .rd_data    (rd_data),
        .u_addr     (u_addr),
        .u_row      (u_row),
        .u_col      (u_col),
        .ram        (ram),
        .res        (res),
        .idle       (seq_idle)
    );

    // One shared address unit; scroll writes reuse an address it gave for a read
    tcce_addr u_addr_unit (
        .row  (u_row),
        .col  (u_col),
        .addr (u_addr)
    );

    tcce_ram #(
        .WIDTH (tcce_pkg::CELL_W),
        .DEPTH (tcce_pkg::CELLS)
    ) u_screen (
        .aclk    (aclk),
        .wr_en   (ram.wr_en),
        .wr_addr (ram.wr_addr),
        .wr_data (ram.wr_data),
        .rd_en   (ram.rd_en),
        .rd_addr (ram.rd_addr),
        .rd_data (rd_data)
    );

    // Load a finished result, hold it while the receiver stalls
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res.valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{tcce_pkg::M_PAD_W{1'b0}},
                             res.prev,
                             tcce_pkg::ROW_OUT_W'(res.row),
                             tcce_pkg::COL_OUT_W'(res.col)};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = seq_idle;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== rtl/tcce_checker.sv =====
// ============================================================================
// tcce_checker
// Port-level checks of the console engine, bound to the top level.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module tcce_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [tcce_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [tcce_pkg::COL_OUT_W-1:0] m_col;
    logic [tcce_pkg::ROW_OUT_W-1:0] m_row;
    tcce_pkg::char_t                m_prev;
    logic                           s_take;
    logic                           m_stall;
    logic                           in_screen;
    logic                           home_ok;

    assign m_col     = m_tdata[tcce_pkg::COL_OUT_W-1:0];
    assign m_row     = m_tdata[tcce_pkg::COL_OUT_W +: tcce_pkg::ROW_OUT_W];
    assign m_prev    = m_tdata[tcce_pkg::COL_OUT_W + tcce_pkg::ROW_OUT_W +: tcce_pkg::CHAR_W];
    assign s_take    = s_tvalid && s_tready;
    assign m_stall   = m_tvalid && !m_tready;
    assign in_screen = (m_col < tcce_pkg::COL_OUT_W'(tcce_pkg::COLUMNS))
                    && (m_row < tcce_pkg::ROW_OUT_W'(tcce_pkg::ROWS));
    assign home_ok   = (m_col != '0) || (m_row != '0) || (m_prev == tcce_pkg::CH_SPACE);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_stall, m_tvalid && $stable(m_tdata), "result not held")

    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_take, !s_tready, "accepted while busy")

    `ASSERT_ALWAYS(a_cursor_range, aclk, aresetn, !m_tvalid || in_screen, "cursor off screen")

    `ASSERT_ALWAYS(a_home_space, aclk, aresetn, !m_tvalid || home_ok, "home must report a space")

endmodule

bind text_console_cursor_engine tcce_checker u_checker (.*);

`default_nettype wire

// ===== tb/tb_text_console_cursor_engine.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_engine
// Self-checking bench for the text console cursor engine. A shadow screen and
// cursor are kept in the bench and updated for every command item the block
// takes. The cursor report that this predicts is then compared field by field
// with each result item. Directed items come first, then three phases of
// random text lines mixed with noise under different back-pressure patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_text_console_cursor_engine;

    // Command value with no enum member; the block reports the cursor only.
    localparam logic [tcce_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;
    localparam tcce_pkg::char_t CH_TILDE = 8'd126;

    // The slowest item is a full-screen sweep, so allow one after the drain.
    localparam int DRAIN_CYCLES = tcce_pkg::CELLS + 100;
    // About 925 items at a full-screen sweep each plus stalls, taken 5x over.
    localparam longint TIMEOUT_NS = 64'd100_000_000;
    localparam int ITEMS_PER_PHASE = 300;

    typedef struct packed {
        logic [tcce_pkg::CMD_W-1:0] cmd;
        tcce_pkg::char_t            code;
    } console_cmd_t;

    typedef struct packed {
        logic [tcce_pkg::COL_OUT_W-1:0] col;
        logic [tcce_pkg::ROW_OUT_W-1:0] row;
        tcce_pkg::char_t                prev;
    } cursor_report_t;

    // Every input starts at a known level.
    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [tcce_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [tcce_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           cfg_we = 1'b0;
    logic [tcce_pkg::COLOR_W-1:0]   cfg_wdata = '0;

    text_console_cursor_engine DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // command[1:0], char_code[9:2]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // cursor_column[6:0], cursor_row[11:7],
                                  // previous_char[19:12]
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Commands waiting for the driver, and cursor reports waiting for the block.
    console_cmd_t   cmd_backlog[$];
    cursor_report_t expected_reports[$];

    int issued_count   = 0;   // items put into the backlog
    int accepted_count = 0;   // items taken by the block
    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    logic s_taken = 1'b0;     // item on s_ was taken at the last rising edge

    // Shadow of the screen store, the cursor and the color register.
    tcce_pkg::cell_t  screen_shadow [tcce_pkg::CELLS];
    int               cur_col;
    int               cur_row;
    tcce_pkg::color_t color_shadow;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow screen model
    // ------------------------------------------------------------------------
    task automatic blank_shadow_row(input int row);
        int x;
        for (x = 0; x < tcce_pkg::COLUMNS; x++)
            screen_shadow[row * tcce_pkg::COLUMNS + x] = {color_shadow, tcce_pkg::CH_SPACE};
    endtask

    // Character left of the cursor; at column 0 it is the last cell of the row above.
    function automatic tcce_pkg::char_t char_left_of_cursor();
        if (cur_col == 0 && cur_row == 0)
            return tcce_pkg::CH_SPACE;
        return screen_shadow[cur_row * tcce_pkg::COLUMNS + cur_col - 1][tcce_pkg::CHAR_W-1:0];
    endfunction

    // Apply one command to the shadow and queue the cursor report it yields.
    task automatic apply_console_cmd(input console_cmd_t item);
        int idx;
        int y;
        cursor_report_t report;
        if (item.cmd == tcce_pkg::CMD_PUT) begin
            if (item.code == tcce_pkg::CH_NEWLINE) begin
                cur_row++;
                cur_col = 0;
            end else if (item.code == tcce_pkg::CH_RETURN) begin
                cur_col = 0;
            end else if (item.code == tcce_pkg::CH_TAB) begin
                // tab leaves everything alone
            end else if (item.code == tcce_pkg::CH_BACKSPACE) begin
                // step back, across a row start if needed, and blank the cell
                if (cur_col > 0) begin
                    cur_col--;
                end else if (cur_row > 0) begin
                    cur_row--;
                    cur_col = tcce_pkg::COLUMNS - 1;
                end
                screen_shadow[cur_row * tcce_pkg::COLUMNS + cur_col] =
                    {color_shadow, tcce_pkg::CH_SPACE};
            end else begin
                screen_shadow[cur_row * tcce_pkg::COLUMNS + cur_col] = {color_shadow, item.code};
                cur_col++;
                if (cur_col >= tcce_pkg::COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
            end
            // Past the bottom row: scroll up one row and blank the new bottom row.
            if (cur_row >= tcce_pkg::ROWS) begin
                for (idx = 0; idx < tcce_pkg::CELLS - tcce_pkg::COLUMNS; idx++)
                    screen_shadow[idx] = screen_shadow[idx + tcce_pkg::COLUMNS];
                blank_shadow_row(tcce_pkg::ROWS - 1);
                cur_row = tcce_pkg::ROWS - 1;
            end
        end else if (item.cmd == tcce_pkg::CMD_CLEAR_ALL) begin
            for (y = 0; y < tcce_pkg::ROWS; y++)
                blank_shadow_row(y);
            cur_col = 0;
            cur_row = 0;
        end else if (item.cmd == tcce_pkg::CMD_CLEAR_ROW) begin
            blank_shadow_row(cur_row);
            cur_col = 0;
        end
        report.col  = tcce_pkg::COL_OUT_W'(cur_col);
        report.row  = tcce_pkg::ROW_OUT_W'(cur_row);
        report.prev = char_left_of_cursor();
        expected_reports.push_back(report);
    endtask

    // ------------------------------------------------------------------------
    // Driver: inputs change on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        console_cmd_t next_cmd;
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        // Load a new item once the current one is gone, or hold it.
        if (!s_tvalid || s_taken) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_cmd = cmd_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(tcce_pkg::S_TDATA_W - tcce_pkg::S_FIELDS_W){1'b0}},
                             next_cmd.code, next_cmd.cmd};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        console_cmd_t   taken_cmd;
        cursor_report_t seen;
        cursor_report_t want;
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            // Check results first: none can stem from an item taken at this edge.
            if (m_tvalid && m_tready) begin
                seen.col  = m_tdata[tcce_pkg::COL_OUT_W-1:0];
                seen.row  = m_tdata[tcce_pkg::COL_OUT_W +: tcce_pkg::ROW_OUT_W];
                seen.prev = m_tdata[tcce_pkg::COL_OUT_W + tcce_pkg::ROW_OUT_W +: tcce_pkg::CHAR_W];
                if (expected_reports.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result expected none actual col=%0d row=%0d prev=%02h",
                             $time, seen.col, seen.row, seen.prev);
                end else begin
                    want = expected_reports.pop_front();
                    if (seen.col !== want.col) begin
                        mismatch_count++;
                        $display("%0t: cursor_column expected %0d actual %0d",
                                 $time, want.col, seen.col);
                    end
                    if (seen.row !== want.row) begin
                        mismatch_count++;
                        $display("%0t: cursor_row expected %0d actual %0d",
                                 $time, want.row, seen.row);
                    end
                    if (seen.prev !== want.prev) begin
                        mismatch_count++;
                        $display("%0t: previous_char expected %02h actual %02h",
                                 $time, want.prev, seen.prev);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                taken_cmd.cmd  = s_tdata[tcce_pkg::CMD_W-1:0];
                taken_cmd.code = s_tdata[tcce_pkg::CMD_W +: tcce_pkg::CHAR_W];
                apply_console_cmd(taken_cmd);
                accepted_count++;
            end
            s_taken <= s_tvalid && s_tready;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_cmd(input logic [tcce_pkg::CMD_W-1:0] cmd,
                             input tcce_pkg::char_t code);
        console_cmd_t item;
        item.cmd  = cmd;
        item.code = code;
        cmd_backlog.push_back(item);
        issued_count++;
    endtask

    // Wait until every queued item was taken and every report has come back.
    task automatic wait_console_idle();
        while (accepted_count != issued_count || expected_reports.size() != 0)
            @(negedge aclk);
    endtask

    // Write the color register; only called while the block is idle.
    task automatic write_text_color(input tcce_pkg::color_t value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        color_shadow = value;
    endtask

    // Mostly lines of text ended by a newline, so the cursor walks down the
    // screen and keeps scrolling; the rest is clears, reserved commands and noise.
    task automatic queue_random_text(input int n_items);
        int start;
        int pick;
        int len;
        int k;
        int r;
        tcce_pkg::char_t code;
        start = issued_count;
        while (issued_count - start < n_items) begin
            pick = $urandom_range(99);
            if (pick < 2) begin
                queue_cmd(tcce_pkg::CMD_CLEAR_ALL, tcce_pkg::char_t'($urandom_range(255)));
            end else if (pick < 5) begin
                queue_cmd(tcce_pkg::CMD_CLEAR_ROW, tcce_pkg::char_t'($urandom_range(255)));
            end else if (pick < 7) begin
                queue_cmd(CMD_RESERVED, tcce_pkg::char_t'($urandom_range(255)));
            end else if (pick < 12) begin
                queue_cmd(tcce_pkg::CMD_PUT, tcce_pkg::char_t'($urandom_range(255)));
            end else begin
                // short lines mostly, now and then one long enough to wrap
                len = ($urandom_range(9) == 0) ? $urandom_range(90, 70) : $urandom_range(20, 0);
                for (k = 0; k < len; k++) begin
                    r = $urandom_range(15);
                    if (r == 0)
                        code = tcce_pkg::CH_BACKSPACE;
                    else if (r == 1)
                        code = ($urandom_range(1) != 0) ? tcce_pkg::CH_TAB : tcce_pkg::CH_RETURN;
                    else if (r == 2)
                        code = tcce_pkg::char_t'($urandom_range(255));
                    else
                        code = tcce_pkg::char_t'($urandom_range(CH_TILDE, tcce_pkg::CH_SPACE));
                    queue_cmd(tcce_pkg::CMD_PUT, code);
                end
                r = $urandom_range(19);
                if (r < 17)
                    queue_cmd(tcce_pkg::CMD_PUT, tcce_pkg::CH_NEWLINE);
                else if (r < 19)
                    queue_cmd(tcce_pkg::CMD_PUT, tcce_pkg::CH_RETURN);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int i;
        color_shadow = tcce_pkg::COLOR_RESET;
        for (i = 0; i < tcce_pkg::CELLS; i++)
            screen_shadow[i] = {tcce_pkg::COLOR_RESET, tcce_pkg::CH_SPACE};
        cur_col = 0;
        cur_row = 0;

        // Hold reset, then release it; the block then sweeps the screen by itself.
        send_idle_pct = 19;
        recv_idle_pct = 51;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: control characters, byte extremes and every command.
        queue_cmd(tcce_pkg::CMD_PUT, tcce_pkg::CH_BACKSPACE);   // backspace at home stays
        queue_cmd(tcce_pkg::CMD_PUT, 8'h41);
        queue_cmd(tcce_pkg::CMD_PUT, 8'h00);
        queue_cmd(tcce_pkg::CMD_PUT, 8'hFF);
        queue_cmd(tcce_pkg::CMD_PUT, tcce_pkg::CH_TAB);
        queue_cmd(tcce_pkg::CMD_PUT, tcce_pkg::CH_RETURN);      // back to home
        queue_cmd(tcce_pkg::CMD_PUT, tcce_pkg::CH_NEWLINE);
        queue_cmd(tcce_pkg::CMD_PUT, tcce_pkg::CH_BACKSPACE);   // across the row start
        queue_cmd(tcce_pkg::CMD_PUT, 8'h78);                    // last column, wraps
        queue_cmd(tcce_pkg::CMD_CLEAR_ROW, 8'hFF);
        queue_cmd(CMD_RESERVED, 8'hAA);
        queue_cmd(tcce_pkg::CMD_PUT, 8'h5A);
        queue_cmd(tcce_pkg::CMD_CLEAR_ALL, 8'h55);
        queue_cmd(tcce_pkg::CMD_PUT, 8'h7E);
        queue_cmd(tcce_pkg::CMD_CLEAR_ROW, 8'h00);              // clear the top row back to home
        wait_console_idle();

        // Phase A: sender idles a little, receiver often.
        write_text_color(8'h00);
        queue_random_text(ITEMS_PER_PHASE);
        wait_console_idle();

        // Phase B: the other way round.
        send_idle_pct = 51;
        recv_idle_pct = 19;
        write_text_color(8'hFF);
        queue_random_text(ITEMS_PER_PHASE);
        wait_console_idle();

        // Phase C: full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_text_color(tcce_pkg::color_t'($urandom_range(254, 1)));
        queue_random_text(ITEMS_PER_PHASE);
        wait_console_idle();

        // Give a stray result time to show up.
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && expected_reports.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
